[rtl/mseu_pkg.sv]
package mseu_pkg;

  localparam int unsigned XLEN    = 32;
  localparam int unsigned REG_AW  = 5;
  localparam int unsigned REG_N   = 32;
  localparam int unsigned IMM_W   = 16;
  localparam int unsigned CMD_W   = 4;
  localparam int unsigned MADDR_W = 10;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 4'd0,
    CMD_SUB  = 4'd1,
    CMD_AND  = 4'd2,
    CMD_OR   = 4'd3,
    CMD_SLT  = 4'd4,
    CMD_LW   = 4'd5,
    CMD_SW   = 4'd6,
    CMD_BEQ  = 4'd7,
    CMD_BNE  = 4'd8,
    CMD_ADDI = 4'd9,
    CMD_J    = 4'd10
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_UNSUP = 2'd2
  } status_e;

  typedef struct packed {
    logic               we;
    logic [REG_AW-1:0]  wreg;
    logic [XLEN-1:0]    wval;
    logic               ld;
    logic               st;
    logic [XLEN-1:0]    addr;
    logic [MADDR_W-1:0] maddr;
    logic               taken;
    status_e            status;
  } ex_res_t;

endpackage

[rtl/mseu_in_if.sv]
interface mseu_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         cmd;
  logic [4:0]         dest_reg;
  logic [4:0]         src_a_reg;
  logic [4:0]         src_b_reg;
  logic signed [15:0] immediate;

  modport source (
    output valid, cmd, dest_reg, src_a_reg, src_b_reg, immediate,
    input  ready
  );
  modport sink (
    input  valid, cmd, dest_reg, src_a_reg, src_b_reg, immediate,
    output ready
  );
endinterface

[rtl/mseu_out_if.sv]
interface mseu_out_if;
  logic               valid;
  logic               ready;
  logic               write_enable;
  logic [4:0]         written_reg;
  logic signed [31:0] written_value;
  logic [9:0]         mem_address;
  logic               branch_taken;
  logic [1:0]         status;

  modport source (
    output valid, write_enable, written_reg, written_value, mem_address,
           branch_taken, status,
    input  ready
  );
  modport sink (
    input  valid, write_enable, written_reg, written_value, mem_address,
           branch_taken, status,
    output ready
  );
endinterface

[rtl/mseu_ram.sv]
module mseu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      // write-first on a same-address collision
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/mseu_exec.sv]
module mseu_exec import mseu_pkg::*; #(
  parameter int unsigned MEM_WORDS = 1024
) (
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [REG_AW-1:0] dest_reg_i,
  input  logic [IMM_W-1:0]  imm_i,
  input  logic [XLEN-1:0]   opa_i,
  input  logic [XLEN-1:0]   opb_i,
  input  logic [XLEN-1:0]   opd_i,
  output ex_res_t           res_o
);

  localparam logic [XLEN-1:0] MemLimit = XLEN'(MEM_WORDS);

  logic [XLEN-1:0] imm_ext;
  logic [XLEN-1:0] addr;
  logic            hit;
  logic            has_write;
  logic [XLEN-1:0] result;
  logic            dest_nz;

  assign imm_ext = {{(XLEN-IMM_W){imm_i[IMM_W-1]}}, imm_i};
  assign addr    = opa_i + imm_ext;
  assign hit     = addr < MemLimit;
  assign dest_nz = dest_reg_i != '0;

  always_comb begin
    has_write    = 1'b0;
    result       = '0;
    res_o        = '0;
    res_o.status = ST_OK;
    res_o.addr   = addr;
    unique case (cmd_e'(cmd_i))
      CMD_ADD: begin
        result    = opa_i + opb_i;
        has_write = 1'b1;
      end
      CMD_SUB: begin
        result    = opa_i - opb_i;
        has_write = 1'b1;
      end
      CMD_AND: begin
        result    = opa_i & opb_i;
        has_write = 1'b1;
      end
      CMD_OR: begin
        result    = opa_i | opb_i;
        has_write = 1'b1;
      end
      CMD_SLT: begin
        result    = {{(XLEN-1){1'b0}}, ($signed(opa_i) < $signed(opb_i))};
        has_write = 1'b1;
      end
      CMD_ADDI: begin
        result    = addr;
        has_write = 1'b1;
      end
      CMD_LW: begin
        if (hit) begin
          res_o.ld    = 1'b1;
          res_o.we    = dest_nz;
          res_o.wreg  = dest_nz ? dest_reg_i : '0;
          res_o.maddr = addr[MADDR_W-1:0];
        end else begin
          res_o.status = ST_RANGE;
        end
      end
      CMD_SW: begin
        if (hit) begin
          res_o.st    = 1'b1;
          res_o.wval  = opd_i;
          res_o.maddr = addr[MADDR_W-1:0];
        end else begin
          res_o.status = ST_RANGE;
        end
      end
      CMD_BEQ: res_o.taken = opa_i == opb_i;
      CMD_BNE: res_o.taken = opa_i != opb_i;
      CMD_J:   res_o.taken = 1'b1;
      default: res_o.status = ST_UNSUP;
    endcase
    if (has_write && dest_nz) begin
      res_o.we   = 1'b1;
      res_o.wreg = dest_reg_i;
      res_o.wval = result;
    end
  end

endmodule

[rtl/mips_subset_execute_unit_core.sv]
// channel | dir | signals                                   | item
// in_i    | in  | valid ready cmd dest_reg src_a_reg         | one decoded instruction
//         |     | src_b_reg immediate                       |
// out_o   | out | valid ready write_enable written_reg      | one result per instruction
//         |     | written_value mem_address branch_taken status |
// three stages: register file read, execute and address, memory read and result
// one item per cycle sustained while out_o.ready is high
// results of earlier items are forwarded from the memory stage into execute
// after reset, registers and data memory are zero-filled with in_i.ready low
// each stage holds while the next one is full and stalled; bubbles close up
module mips_subset_execute_unit_core import mseu_pkg::*; #(
  parameter int unsigned MEM_WORDS = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mseu_in_if.sink    in_i,
  mseu_out_if.source out_o
);

  localparam int unsigned AW    = $clog2(MEM_WORDS);
  localparam int unsigned CLR_N = (MEM_WORDS > REG_N) ? MEM_WORDS : REG_N;
  localparam int unsigned CLW   = $clog2(CLR_N);

  logic           clearing_q;
  logic [CLW-1:0] clr_cnt_q;

  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic out_adv, s2_free, s1_free, s1_adv, in_acc;

  logic [CMD_W-1:0]  s1_cmd_q;
  logic [REG_AW-1:0] s1_dest_q, s1_srca_q, s1_srcb_q;
  logic [IMM_W-1:0]  s1_imm_q;

  ex_res_t ex_res;
  ex_res_t s2_q;

  logic [XLEN-1:0] rf_a, rf_b, rf_d;
  logic [XLEN-1:0] opa, opb, opd;
  logic [XLEN-1:0] mem_rdata;
  logic [XLEN-1:0] s2_val;

  logic              rf_we;
  logic [REG_AW-1:0] rf_waddr;
  logic [XLEN-1:0]   rf_wdata;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [XLEN-1:0] mem_wdata;
  logic            mem_re;

  logic               out_we_q;
  logic [REG_AW-1:0]  out_wreg_q;
  logic [XLEN-1:0]    out_wval_q;
  logic [MADDR_W-1:0] out_maddr_q;
  logic               out_taken_q;
  status_e            out_status_q;

  // pipeline flow
  assign out_adv = !out_valid_q || out_o.ready;
  assign s2_free = !s2_valid_q || out_adv;
  assign s1_free = !s1_valid_q || s2_free;
  assign s1_adv  = s1_valid_q && s2_free;
  assign in_i.ready = s1_free && !clearing_q;
  assign in_acc  = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == CLW'(CLR_N - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= in_acc;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_adv) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q  <= in_i.cmd;
      s1_dest_q <= in_i.dest_reg;
      s1_srca_q <= in_i.src_a_reg;
      s1_srcb_q <= in_i.src_b_reg;
      s1_imm_q  <= in_i.immediate;
    end
    if (s1_adv) begin
      s2_q <= ex_res;
    end
    if (s2_valid_q && out_adv) begin
      out_we_q     <= s2_q.we;
      out_wreg_q   <= s2_q.wreg;
      out_wval_q   <= s2_val;
      out_maddr_q  <= s2_q.maddr;
      out_taken_q  <= s2_q.taken;
      out_status_q <= s2_q.status;
    end
  end

  // register file, one copy per read port
  assign rf_we    = clearing_q || (s2_valid_q && out_adv && s2_q.we);
  assign rf_waddr = clearing_q ? clr_cnt_q[REG_AW-1:0] : s2_q.wreg;
  assign rf_wdata = clearing_q ? '0 : s2_val;

  mseu_ram #(.WIDTH(XLEN), .DEPTH(REG_N)) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .re_i    (in_acc),
    .raddr_i (in_i.src_a_reg),
    .rdata_o (rf_a)
  );

  mseu_ram #(.WIDTH(XLEN), .DEPTH(REG_N)) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .re_i    (in_acc),
    .raddr_i (in_i.src_b_reg),
    .rdata_o (rf_b)
  );

  mseu_ram #(.WIDTH(XLEN), .DEPTH(REG_N)) u_rf_d (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .re_i    (in_acc),
    .raddr_i (in_i.dest_reg),
    .rdata_o (rf_d)
  );

  // forward from the memory stage
  assign s2_val = (s2_q.ld && s2_q.we) ? mem_rdata : s2_q.wval;
  assign opa = (s2_valid_q && s2_q.we && s2_q.wreg == s1_srca_q) ? s2_val : rf_a;
  assign opb = (s2_valid_q && s2_q.we && s2_q.wreg == s1_srcb_q) ? s2_val : rf_b;
  assign opd = (s2_valid_q && s2_q.we && s2_q.wreg == s1_dest_q) ? s2_val : rf_d;

  mseu_exec #(.MEM_WORDS(MEM_WORDS)) u_exec (
    .cmd_i      (s1_cmd_q),
    .dest_reg_i (s1_dest_q),
    .imm_i      (s1_imm_q),
    .opa_i      (opa),
    .opb_i      (opb),
    .opd_i      (opd),
    .res_o      (ex_res)
  );

  // data memory
  always_comb begin
    if (clearing_q) begin
      mem_we    = {1'b0, clr_cnt_q} < (CLW+1)'(MEM_WORDS);
      mem_waddr = clr_cnt_q[AW-1:0];
      mem_wdata = '0;
    end else begin
      mem_we    = s1_adv && ex_res.st;
      mem_waddr = ex_res.addr[AW-1:0];
      mem_wdata = ex_res.wval;
    end
  end

  assign mem_re = s1_adv && ex_res.ld;

  mseu_ram #(.WIDTH(XLEN), .DEPTH(MEM_WORDS)) u_dmem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (ex_res.addr[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  assign out_o.valid         = out_valid_q;
  assign out_o.write_enable  = out_we_q;
  assign out_o.written_reg   = out_wreg_q;
  assign out_o.written_value = out_wval_q;
  assign out_o.mem_address   = out_maddr_q;
  assign out_o.branch_taken  = out_taken_q;
  assign out_o.status        = out_status_q;

endmodule

[tb/mseu_tb_pkg.sv]
package mseu_tb_pkg;
  import mseu_pkg::*;

  localparam int unsigned TB_MEM_WORDS = 1024;

  typedef struct packed {
    logic [3:0]         cmd;
    logic [4:0]         dest;
    logic [4:0]         src_a;
    logic [4:0]         src_b;
    logic signed [15:0] imm;
  } instr_t;

  typedef struct packed {
    logic        we;
    logic [4:0]  wreg;
    logic [31:0] wval;
    logic [9:0]  maddr;
    logic        taken;
    status_e     status;
  } exec_result_t;

  class exec_scoreboard;
    logic [31:0]  regs [32];
    logic [31:0]  mem [TB_MEM_WORDS];
    exec_result_t expected_results [$];
    int unsigned  errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    // execute one accepted instruction on the shadow state
    function void note_instr(instr_t it);
      exec_result_t r;
      logic [31:0]  a, b, imm, res, addr, v;
      bit           wr;
      a   = regs[it.src_a];
      b   = regs[it.src_b];
      imm = {{16{it.imm[15]}}, it.imm};
      r   = '0;
      r.status = ST_OK;
      res = '0;
      wr  = 1'b0;
      case (it.cmd)
        CMD_ADD:  begin res = a + b; wr = 1'b1; end
        CMD_SUB:  begin res = a - b; wr = 1'b1; end
        CMD_AND:  begin res = a & b; wr = 1'b1; end
        CMD_OR:   begin res = a | b; wr = 1'b1; end
        CMD_SLT:  begin res = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0; wr = 1'b1; end
        CMD_ADDI: begin res = a + imm; wr = 1'b1; end
        CMD_LW, CMD_SW: begin
          addr = a + imm;
          if (addr >= TB_MEM_WORDS) begin
            r.status = ST_RANGE;
          end else if (it.cmd == CMD_LW) begin
            r.maddr = addr[9:0];
            res = mem[addr];
            wr = 1'b1;
          end else begin
            v = regs[it.dest];
            r.maddr = addr[9:0];
            mem[addr] = v;
            r.wval = v;
          end
        end
        CMD_BEQ:  r.taken = (a == b);
        CMD_BNE:  r.taken = (a != b);
        CMD_J:    r.taken = 1'b1;
        default:  r.status = ST_UNSUP;
      endcase
      if (wr && it.dest != 5'd0) begin
        regs[it.dest] = res;
        r.we   = 1'b1;
        r.wreg = it.dest;
        r.wval = res;
      end
      expected_results.push_back(r);
    endfunction

    function void check_result(exec_result_t got);
      exec_result_t exp;
      if (expected_results.size() == 0) begin
        $error("result with no instruction pending");
        errors++;
        return;
      end
      exp = expected_results.pop_front();
      if (got.we !== exp.we) begin
        $error("write_enable: expected %0h actual %0h", exp.we, got.we);
        errors++;
      end
      if (got.wreg !== exp.wreg) begin
        $error("written_reg: expected %0d actual %0d", exp.wreg, got.wreg);
        errors++;
      end
      if (got.wval !== exp.wval) begin
        $error("written_value: expected %08h actual %08h", exp.wval, got.wval);
        errors++;
      end
      if (got.maddr !== exp.maddr) begin
        $error("mem_address: expected %0d actual %0d", exp.maddr, got.maddr);
        errors++;
      end
      if (got.taken !== exp.taken) begin
        $error("branch_taken: expected %0h actual %0h", exp.taken, got.taken);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d actual %0d", exp.status, got.status);
        errors++;
      end
    endfunction
  endclass

endpackage

[tb/mips_subset_execute_unit_core_tb.sv]
module mips_subset_execute_unit_core_tb;
  import mseu_pkg::*;
  import mseu_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i;
  logic rst_ni;

  mseu_in_if  in_if ();
  mseu_out_if out_if ();

  mips_subset_execute_unit_core #(
    .MEM_WORDS(TB_MEM_WORDS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  exec_scoreboard sb = new();

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_cnt;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // receiver side
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cnt > 0) begin
        out_if.ready <= 1'b0;
        hold_cnt = hold_cnt - 1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    instr_t it;
    if (rst_ni && in_if.valid && in_if.ready) begin
      it.cmd   = in_if.cmd;
      it.dest  = in_if.dest_reg;
      it.src_a = in_if.src_a_reg;
      it.src_b = in_if.src_b_reg;
      it.imm   = in_if.immediate;
      sb.note_instr(it);
    end
  end

  always @(posedge clk_i) begin
    exec_result_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.we     = out_if.write_enable;
      got.wreg   = out_if.written_reg;
      got.wval   = out_if.written_value;
      got.maddr  = out_if.mem_address;
      got.taken  = out_if.branch_taken;
      got.status = status_e'(out_if.status);
      sb.check_result(got);
    end
  end

  function automatic instr_t mk(logic [3:0] cmd, logic [4:0] dest, logic [4:0] src_a,
                                logic [4:0] src_b, int imm);
    instr_t it;
    it.cmd   = cmd;
    it.dest  = dest;
    it.src_a = src_a;
    it.src_b = src_b;
    it.imm   = 16'(imm);
    return it;
  endfunction

  function automatic instr_t gen_instr();
    instr_t      it;
    int unsigned pick;
    int          want;
    longint      diff;
    it.dest  = 5'($urandom);
    it.src_a = 5'($urandom);
    it.src_b = 5'($urandom);
    it.imm   = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 15) it.cmd = CMD_ADDI;
    else if (pick < 30) it.cmd = CMD_LW;
    else if (pick < 45) it.cmd = CMD_SW;
    else if (pick < 50) it.cmd = 4'($urandom_range(15, 11));
    else it.cmd = 4'($urandom_range(10));
    // small bases so that loads and stores land in memory
    if (it.cmd == CMD_ADDI && $urandom_range(1)) begin
      it.src_a = 5'd0;
      it.imm   = 16'(int'($urandom_range(1100)) - 40);
    end
    if ((it.cmd == CMD_LW || it.cmd == CMD_SW) && $urandom_range(9) < 7) begin
      case ($urandom_range(7))
        0:       want = 0;
        1:       want = TB_MEM_WORDS - 1;
        2:       want = $urandom_range(7);
        default: want = $urandom_range(TB_MEM_WORDS - 1);
      endcase
      diff = longint'(want) - longint'($signed(sb.regs[it.src_a]));
      if (diff >= -32768 && diff <= 32767) begin
        it.imm = 16'(diff);
      end else begin
        it.src_a = 5'd0;
        it.imm   = 16'(want);
      end
    end else if ((it.cmd == CMD_LW || it.cmd == CMD_SW) && $urandom_range(1)) begin
      // just outside either end
      it.src_a = 5'd0;
      it.imm   = $urandom_range(1) ? 16'(-1) : 16'(TB_MEM_WORDS + $urandom_range(3));
    end
    if ((it.cmd == CMD_BEQ || it.cmd == CMD_BNE) && $urandom_range(2) == 0) begin
      it.src_b = it.src_a;
    end
    return it;
  endfunction

  task automatic send_instr(bit rnd, instr_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    if (rnd) it = gen_instr();
    in_if.valid     <= 1'b1;
    in_if.cmd       <= it.cmd;
    in_if.dest_reg  <= it.dest;
    in_if.src_a_reg <= it.src_a;
    in_if.src_b_reg <= it.src_b;
    in_if.immediate <= it.imm;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  initial begin
    instr_t      dir_q [$];
    int unsigned idle_tab [4];
    int unsigned stall_tab [4];
    idle_tab  = '{0, 71, 0, 17};
    stall_tab = '{0, 0, 71, 17};
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_cnt        = 0;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.cmd       = '0;
    in_if.dest_reg  = '0;
    in_if.src_a_reg = '0;
    in_if.src_b_reg = '0;
    in_if.immediate = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    dir_q.push_back(mk(CMD_ADDI, 5'd1, 5'd0, 5'd0, 32767));
    dir_q.push_back(mk(CMD_ADDI, 5'd2, 5'd0, 5'd0, -32768));
    dir_q.push_back(mk(CMD_ADD, 5'd3, 5'd1, 5'd2, 0));
    dir_q.push_back(mk(CMD_SUB, 5'd4, 5'd2, 5'd1, 0));
    dir_q.push_back(mk(CMD_ADDI, 5'd5, 5'd0, 5'd0, -1));
    dir_q.push_back(mk(CMD_ADD, 5'd6, 5'd5, 5'd5, 0));
    dir_q.push_back(mk(CMD_SUB, 5'd7, 5'd0, 5'd5, 0));
    dir_q.push_back(mk(CMD_AND, 5'd8, 5'd1, 5'd5, 0));
    dir_q.push_back(mk(CMD_OR, 5'd9, 5'd1, 5'd2, 0));
    dir_q.push_back(mk(CMD_SLT, 5'd10, 5'd2, 5'd1, 0));
    dir_q.push_back(mk(CMD_SLT, 5'd11, 5'd1, 5'd2, 0));
    dir_q.push_back(mk(CMD_ADD, 5'd0, 5'd1, 5'd1, 0));
    dir_q.push_back(mk(CMD_SW, 5'd1, 5'd0, 5'd0, 0));
    dir_q.push_back(mk(CMD_SW, 5'd5, 5'd0, 5'd0, TB_MEM_WORDS - 1));
    dir_q.push_back(mk(CMD_LW, 5'd12, 5'd0, 5'd0, TB_MEM_WORDS - 1));
    dir_q.push_back(mk(CMD_LW, 5'd13, 5'd0, 5'd0, 0));
    dir_q.push_back(mk(CMD_LW, 5'd0, 5'd0, 5'd0, 0));
    dir_q.push_back(mk(CMD_LW, 5'd14, 5'd0, 5'd0, -1));
    dir_q.push_back(mk(CMD_SW, 5'd1, 5'd0, 5'd0, TB_MEM_WORDS));
    dir_q.push_back(mk(CMD_BEQ, 5'd0, 5'd1, 5'd1, 0));
    dir_q.push_back(mk(CMD_BEQ, 5'd0, 5'd1, 5'd2, 0));
    dir_q.push_back(mk(CMD_BNE, 5'd0, 5'd1, 5'd2, 0));
    dir_q.push_back(mk(CMD_BNE, 5'd0, 5'd3, 5'd3, 0));
    dir_q.push_back(mk(CMD_J, 5'd31, 5'd31, 5'd31, -1));
    dir_q.push_back(mk(4'd11, 5'd15, 5'd1, 5'd2, 5));
    dir_q.push_back(mk(4'd15, 5'd31, 5'd31, 5'd31, -1));
    foreach (dir_q[i]) send_instr(1'b0, dir_q[i]);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_tab[p];
      recv_stall_pct = stall_tab[p];
      // long receiver hold-off with the sender still pushing
      if (p == 0) hold_cnt = 300;
      for (int n = 0; n < 175; n++) send_instr(1'b1, '0);
    end
    @(negedge clk_i);
    in_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
